// ===== hdl/dtaq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtaq_pkg
// Shared sizes, codes and the tree table entry for the depth-first tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package dtaq_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int MAX_DEGREE  = 32;
   localparam int STACK_DEPTH = 4096;

   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int CNT_W    = NODE_W + 1;
   localparam int LEV_W    = NODE_W + 1;
   localparam int DEG_AW   = $clog2(MAX_DEGREE);
   localparam int LEN_W    = DEG_AW + 1;
   localparam int NB_AW    = NODE_W + DEG_AW;
   localparam int STK_AW   = $clog2(STACK_DEPTH);
   localparam int SP_W     = STK_AW + 1;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IW   = 1;

   // appended entries per list; slot zero stands for the hub node
   localparam logic [LEN_W-1:0] LIST_CAP = LEN_W'(MAX_DEGREE - 1);

   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BUILD = 3'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DESC  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_LCA   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 3'd4;

   localparam logic [CSR_IW-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IW-1:0] CSR_ROOT_NODE  = 1'd1;

   typedef struct packed {
      logic              vis;
      logic [LEV_W-1:0]  lev;
      logic [NODE_W-1:0] par;
   } tree_entry_type;

endpackage

`default_nettype wire

// ===== hdl/dfs_tree_with_ancestor_queries.sv =====
// ----------------------------------------------------------------------------
// dfs_tree_with_ancestor_queries
// Adjacency-list graph store with depth-first tree build and ancestor queries.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                  handshake
//  req       in         req_kind, req_node_a, req_node_b       req_valid/req_stall
//  rsp       out        rsp_status ... rsp_common_ancestor     rsp_valid/rsp_stall
//  csr       in         csr_index, csr_data                    csr_wr_en
//
//  Clear and reset sweep the list length RAM; no req is taken meanwhile.
//  Add edge: read both list lengths, check room, append to each list. Build:
//  clear the tree table and seed the root, then pop nodes and push unvisited
//  neighbours. Node query: read the node's tree entry. Descendant test: read
//  b's level, then climb a. Common ancestor: climb both to one level, then step both up together.
//  A finished result sits in the rsp register; the next req is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_tree_with_ancestor_queries (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dtaq_pkg::KIND_W-1:0]     req_kind,
   input  logic [dtaq_pkg::NODE_W-1:0]     req_node_a,
   input  logic [dtaq_pkg::NODE_W-1:0]     req_node_b,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [dtaq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [dtaq_pkg::NODE_W-1:0]     rsp_parent_node,
   output logic                            rsp_has_parent,
   output logic [dtaq_pkg::LEV_W-1:0]      rsp_depth_level,
   output logic                            rsp_is_descendant,
   output logic [dtaq_pkg::NODE_W-1:0]     rsp_common_ancestor,
   input  logic                            csr_wr_en,
   input  logic [dtaq_pkg::CSR_IW-1:0]     csr_index,
   input  logic [dtaq_pkg::CNT_W-1:0]      csr_data
);

   import dtaq_pkg::*;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_CLR, S_DONE,
      E_RDU, E_RDV, E_CHK, E_WR2,
      B_CLR, B_ROOT, B_POP, B_V, B_VCHK, N_RD, N_W, P_RD, P_CHK, P_NEXT,
      Q_RD, Q_W, Q_RDB, Q_LB, C_RD, C_CHK, L_CHK, L_RDA, L_RDB, L_WB
   } state_type;

   localparam int TE_W = $bits(tree_entry_type);

   state_type             state_ff, state_in;
   logic [NODE_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]      ncount_ff, ncount_in;
   logic [NODE_W-1:0]     root_ff, root_in;
   logic                  ready_ff, ready_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [NODE_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [LEN_W-1:0]      lu_ff, lu_in, lv_ff, lv_in, k_ff, k_in;
   logic [SP_W-1:0]       sp_ff, sp_in;
   logic [NODE_W-1:0]     v_ff, v_in, w_ff, w_in, c_ff, c_in;
   logic [LEV_W-1:0]      levv_ff, levv_in, tgt_ff, tgt_in;
   logic                  hub_ff, hub_in, zero_ff, zero_in, phase_ff, phase_in;
   logic [CNT_W-1:0]      guard_ff, guard_in;
   tree_entry_type        ea_ff, ea_in, eb_ff, eb_in;

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [NODE_W-1:0]     res_par_ff, res_par_in, res_anc_ff, res_anc_in;
   logic                  res_hasp_ff, res_hasp_in, res_desc_ff, res_desc_in;
   logic [LEV_W-1:0]      res_lev_ff, res_lev_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]     rsp_par_ff, rsp_par_in, rsp_anc_ff, rsp_anc_in;
   logic                  rsp_hasp_ff, rsp_hasp_in, rsp_desc_ff, rsp_desc_in;
   logic [LEV_W-1:0]      rsp_lev_ff, rsp_lev_in;

   // memory ports
   logic                  len_we, len_re;
   logic [NODE_W-1:0]     len_waddr, len_raddr;
   logic [LEN_W-1:0]      len_wdata, len_rd;
   logic                  nb_we, nb_re;
   logic [NB_AW-1:0]      nb_waddr, nb_raddr;
   logic [NODE_W-1:0]     nb_wdata, nb_rd;
   logic                  tree_we, tree_re;
   logic [NODE_W-1:0]     tree_waddr, tree_raddr;
   tree_entry_type        tree_wdata, tree_rd;
   logic [TE_W-1:0]       tree_rd_raw;
   logic                  stk_we, stk_re;
   logic [STK_AW-1:0]     stk_waddr, stk_raddr;
   logic [NODE_W-1:0]     stk_wdata, stk_rd;

   logic [CNT_W-1:0]      live_n;
   logic [LEN_W:0]        lu_plus2;

   assign tree_rd = tree_entry_type'(tree_rd_raw);

   always_comb begin
      if (ncount_ff == '0) begin
         live_n = CNT_W'(1);
      end else if (ncount_ff > CNT_W'(MAX_NODES)) begin
         live_n = CNT_W'(MAX_NODES);
      end else begin
         live_n = ncount_ff;
      end
   end

   assign lu_plus2 = {1'b0, lu_ff} + (LEN_W+1)'(2);

   dtaq_ram #(.WIDTH(LEN_W), .DEPTH(MAX_NODES)) u_len_ram (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_en(len_re), .rd_addr(len_raddr), .rd_data(len_rd)
   );

   dtaq_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_DEGREE)) u_nb_ram (
      .clock(clock), .wr_en(nb_we), .wr_addr(nb_waddr), .wr_data(nb_wdata),
      .rd_en(nb_re), .rd_addr(nb_raddr), .rd_data(nb_rd)
   );

   dtaq_ram #(.WIDTH(TE_W), .DEPTH(MAX_NODES)) u_tree_ram (
      .clock(clock), .wr_en(tree_we), .wr_addr(tree_waddr), .wr_data(tree_wdata),
      .rd_en(tree_re), .rd_addr(tree_raddr), .rd_data(tree_rd_raw)
   );

   dtaq_ram #(.WIDTH(NODE_W), .DEPTH(STACK_DEPTH)) u_stk_ram (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_en(stk_re), .rd_addr(stk_raddr), .rd_data(stk_rd)
   );

   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  ncount_in = ncount_ff;
      root_in = root_ff;    ready_in = ready_ff;  kind_in = kind_ff;
      a_in = a_ff;  b_in = b_ff;  lu_in = lu_ff;  lv_in = lv_ff;  k_in = k_ff;
      sp_in = sp_ff;  v_in = v_ff;  w_in = w_ff;  c_in = c_ff;
      levv_in = levv_ff;  tgt_in = tgt_ff;  hub_in = hub_ff;  zero_in = zero_ff;
      phase_in = phase_ff;  guard_in = guard_ff;  ea_in = ea_ff;  eb_in = eb_ff;
      res_status_in = res_status_ff;  res_par_in = res_par_ff;
      res_anc_in = res_anc_ff;  res_hasp_in = res_hasp_ff;
      res_desc_in = res_desc_ff;  res_lev_in = res_lev_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_status_in = rsp_status_ff;
      rsp_par_in = rsp_par_ff;  rsp_anc_in = rsp_anc_ff;
      rsp_hasp_in = rsp_hasp_ff;  rsp_desc_in = rsp_desc_ff;
      rsp_lev_in = rsp_lev_ff;

      len_we = 1'b0;  len_re = 1'b0;  len_waddr = '0;  len_raddr = '0;
      len_wdata = '0;
      nb_we = 1'b0;  nb_re = 1'b0;  nb_waddr = '0;  nb_raddr = '0;  nb_wdata = '0;
      tree_we = 1'b0;  tree_re = 1'b0;  tree_waddr = '0;  tree_raddr = '0;
      tree_wdata = '0;
      stk_we = 1'b0;  stk_re = 1'b0;  stk_waddr = '0;  stk_raddr = '0;
      stk_wdata = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            len_we = 1'b1;  len_waddr = cnt_ff;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_CLR: begin
            len_we = 1'b1;  len_waddr = cnt_ff;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = S_DONE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;  a_in = req_node_a;  b_in = req_node_b;
               res_status_in = ST_OK;  res_par_in = '0;  res_anc_in = '0;
               res_hasp_in = 1'b0;  res_desc_in = 1'b0;  res_lev_in = '0;
               state_in = S_DONE;
               case (req_kind)
                  KIND_CLEAR: begin
                     ready_in = 1'b0;  cnt_in = '0;  state_in = S_CLR;
                  end
                  KIND_EDGE: begin
                     if (req_node_a == '0 || req_node_b == '0 ||
                         {1'b0, req_node_a} >= live_n ||
                         {1'b0, req_node_b} >= live_n) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        state_in = E_RDU;
                     end
                  end
                  KIND_BUILD: begin
                     ready_in = 1'b0;
                     if ({1'b0, root_ff} >= live_n) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        cnt_in = '0;  state_in = B_CLR;
                     end
                  end
                  KIND_QUERY, KIND_DESC, KIND_LCA: begin
                     if (!ready_ff) begin
                        res_status_in = ST_NOT_BUILT;
                     end else if ({1'b0, req_node_a} >= live_n ||
                                  (req_kind != KIND_QUERY &&
                                   {1'b0, req_node_b} >= live_n)) begin
                        res_status_in = ST_RANGE;
                     end else if (req_kind == KIND_QUERY) begin
                        state_in = Q_RD;
                     end else if (req_kind == KIND_DESC && req_node_a == req_node_b) begin
                        res_desc_in = 1'b1;
                     end else begin
                        state_in = Q_RDB;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;  rsp_status_in = res_status_ff;
               rsp_par_in = res_par_ff;  rsp_anc_in = res_anc_ff;
               rsp_hasp_in = res_hasp_ff;  rsp_desc_in = res_desc_ff;
               rsp_lev_in = res_lev_ff;
               state_in = S_IDLE;
            end
         end
         // edge append: read both lengths, check room, append to each list
         E_RDU: begin
            len_re = 1'b1;  len_raddr = a_ff;  state_in = E_RDV;
         end
         E_RDV: begin
            lu_in = len_rd;  len_re = 1'b1;  len_raddr = b_ff;  state_in = E_CHK;
         end
         E_CHK: begin
            if ((a_ff == b_ff && lu_plus2 > {1'b0, LIST_CAP}) ||
                (a_ff != b_ff && (lu_ff >= LIST_CAP || len_rd >= LIST_CAP))) begin
               res_status_in = ST_FULL;  state_in = S_DONE;
            end else begin
               len_we = 1'b1;  len_waddr = a_ff;  len_wdata = lu_ff + LEN_W'(1);
               nb_we = 1'b1;  nb_waddr = {a_ff, len_wdata[DEG_AW-1:0]};
               nb_wdata = b_ff;
               lv_in = (a_ff == b_ff) ? lu_ff + LEN_W'(1) : len_rd;
               state_in = E_WR2;
            end
         end
         E_WR2: begin
            len_we = 1'b1;  len_waddr = b_ff;  len_wdata = lv_ff + LEN_W'(1);
            nb_we = 1'b1;  nb_waddr = {b_ff, len_wdata[DEG_AW-1:0]};
            nb_wdata = a_ff;
            state_in = S_DONE;
         end
         // build: wipe tree table, seed the root, then pop until empty or overflow
         B_CLR: begin
            tree_we = 1'b1;  tree_waddr = cnt_ff;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = B_ROOT;
            end
         end
         B_ROOT: begin
            tree_we = 1'b1;  tree_waddr = root_ff;
            tree_wdata.lev = LEV_W'(1);
            stk_we = 1'b1;  stk_waddr = '0;  stk_wdata = root_ff;
            sp_in = SP_W'(1);
            state_in = B_POP;
         end
         B_POP: begin
            if (sp_ff == '0) begin
               ready_in = 1'b1;  state_in = S_DONE;
            end else begin
               sp_in = sp_ff - SP_W'(1);
               stk_re = 1'b1;  stk_raddr = sp_in[STK_AW-1:0];
               state_in = B_V;
            end
         end
         B_V: begin
            v_in = stk_rd;
            if ({1'b0, stk_rd} >= live_n) begin
               state_in = B_POP;
            end else begin
               tree_re = 1'b1;  tree_raddr = stk_rd;
               len_re = 1'b1;  len_raddr = stk_rd;
               state_in = B_VCHK;
            end
         end
         B_VCHK: begin
            if (tree_rd.vis) begin
               state_in = B_POP;
            end else begin
               tree_we = 1'b1;  tree_waddr = v_ff;
               tree_wdata = tree_rd;  tree_wdata.vis = 1'b1;
               levv_in = tree_rd.lev;
               if (v_ff == '0) begin
                  hub_in = 1'b1;
                  w_in = NODE_W'(live_n - CNT_W'(1));
                  state_in = (live_n > CNT_W'(1)) ? P_RD : B_POP;
               end else begin
                  hub_in = 1'b0;  k_in = len_rd;
                  if (len_rd != '0) begin
                     zero_in = 1'b0;  state_in = N_RD;
                  end else begin
                     zero_in = 1'b1;  w_in = '0;  state_in = P_RD;
                  end
               end
            end
         end
         N_RD: begin
            nb_re = 1'b1;  nb_raddr = {v_ff, k_ff[DEG_AW-1:0]};  state_in = N_W;
         end
         N_W: begin
            w_in = nb_rd;
            // drop stale neighbours beyond the live node range
            state_in = ({1'b0, nb_rd} < live_n) ? P_RD : P_NEXT;
         end
         P_RD: begin
            tree_re = 1'b1;  tree_raddr = w_ff;  state_in = P_CHK;
         end
         P_CHK: begin
            if (tree_rd.vis) begin
               state_in = P_NEXT;
            end else if (sp_ff >= SP_W'(STACK_DEPTH)) begin
               sp_in = '0;  res_status_in = ST_OVERFLOW;  state_in = S_DONE;
            end else begin
               stk_we = 1'b1;  stk_waddr = sp_ff[STK_AW-1:0];  stk_wdata = w_ff;
               sp_in = sp_ff + SP_W'(1);
               tree_we = 1'b1;  tree_waddr = w_ff;
               tree_wdata.lev = levv_ff + LEV_W'(1);
               tree_wdata.par = v_ff;
               state_in = P_NEXT;
            end
         end
         P_NEXT: begin
            if (hub_ff) begin
               if (w_ff > NODE_W'(1)) begin
                  w_in = w_ff - NODE_W'(1);  state_in = P_RD;
               end else begin
                  state_in = B_POP;
               end
            end else if (zero_ff) begin
               state_in = B_POP;
            end else if (k_ff > LEN_W'(1)) begin
               k_in = k_ff - LEN_W'(1);  state_in = N_RD;
            end else begin
               // list done: hub link goes last
               zero_in = 1'b1;  w_in = '0;  state_in = P_RD;
            end
         end
         Q_RD: begin
            tree_re = 1'b1;  tree_raddr = a_ff;  state_in = Q_W;
         end
         Q_W: begin
            res_lev_in = tree_rd.lev;
            if (tree_rd.lev >= LEV_W'(2)) begin
               res_hasp_in = 1'b1;  res_par_in = tree_rd.par;
            end
            state_in = S_DONE;
         end
         Q_RDB: begin
            tree_re = 1'b1;  tree_raddr = b_ff;  state_in = Q_LB;
         end
         Q_LB: begin
            tgt_in = tree_rd.lev;  c_in = a_ff;  guard_in = '0;  phase_in = 1'b0;
            state_in = C_RD;
         end
         // climb c toward level tgt, one parent a step
         C_RD: begin
            tree_re = 1'b1;  tree_raddr = c_ff;  state_in = C_CHK;
         end
         C_CHK: begin
            if (tree_rd.lev > tgt_ff && tree_rd.lev >= LEV_W'(2) &&
                guard_ff < CNT_W'(MAX_NODES)) begin
               c_in = tree_rd.par;  guard_in = guard_ff + CNT_W'(1);
               state_in = C_RD;
            end else if (kind_ff == KIND_DESC) begin
               res_desc_in = (c_ff == b_ff);  state_in = S_DONE;
            end else if (!phase_ff) begin
               a_in = c_ff;  ea_in = tree_rd;  tgt_in = tree_rd.lev;
               c_in = b_ff;  guard_in = '0;  phase_in = 1'b1;
               state_in = C_RD;
            end else begin
               b_in = c_ff;  eb_in = tree_rd;  guard_in = '0;
               state_in = L_CHK;
            end
         end
         L_CHK: begin
            if (a_ff != b_ff && ea_ff.lev >= LEV_W'(2) && eb_ff.lev >= LEV_W'(2) &&
                guard_ff < CNT_W'(MAX_NODES)) begin
               a_in = ea_ff.par;  b_in = eb_ff.par;
               guard_in = guard_ff + CNT_W'(1);
               state_in = L_RDA;
            end else begin
               res_anc_in = a_ff;  state_in = S_DONE;
            end
         end
         L_RDA: begin
            tree_re = 1'b1;  tree_raddr = a_ff;  state_in = L_RDB;
         end
         L_RDB: begin
            ea_in = tree_rd;  tree_re = 1'b1;  tree_raddr = b_ff;  state_in = L_WB;
         end
         L_WB: begin
            eb_in = tree_rd;  state_in = L_CHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            CSR_NODE_COUNT: begin
               ncount_in = csr_data;  ready_in = 1'b0;
            end
            CSR_ROOT_NODE: begin
               root_in = csr_data[NODE_W-1:0];  ready_in = 1'b0;
            end
            default: begin
               ready_in = ready_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         ncount_ff    <= CNT_W'(MAX_NODES);
         root_ff      <= '0;
         ready_ff     <= 1'b0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ncount_ff    <= ncount_in;
         root_ff      <= root_in;
         ready_ff     <= ready_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;  a_ff <= a_in;  b_ff <= b_in;
      lu_ff <= lu_in;  lv_ff <= lv_in;  k_ff <= k_in;
      v_ff <= v_in;  w_ff <= w_in;  c_ff <= c_in;
      levv_ff <= levv_in;  tgt_ff <= tgt_in;
      hub_ff <= hub_in;  zero_ff <= zero_in;  phase_ff <= phase_in;
      guard_ff <= guard_in;  ea_ff <= ea_in;  eb_ff <= eb_in;
      res_status_ff <= res_status_in;  res_par_ff <= res_par_in;
      res_anc_ff <= res_anc_in;  res_hasp_ff <= res_hasp_in;
      res_desc_ff <= res_desc_in;  res_lev_ff <= res_lev_in;
      rsp_status_ff <= rsp_status_in;  rsp_par_ff <= rsp_par_in;
      rsp_anc_ff <= rsp_anc_in;  rsp_hasp_ff <= rsp_hasp_in;
      rsp_desc_ff <= rsp_desc_in;  rsp_lev_ff <= rsp_lev_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_parent_node     = rsp_par_ff;
   assign rsp_has_parent      = rsp_hasp_ff;
   assign rsp_depth_level     = rsp_lev_ff;
   assign rsp_is_descendant   = rsp_desc_ff;
   assign rsp_common_ancestor = rsp_anc_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("walk stack pointer beyond depth");

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      (len_we |-> len_wdata <= LIST_CAP))
      else $error("list length written beyond capacity");

   a_csr_drops_tree: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !ready_ff)
      else $error("tree still marked built after register write");

endmodule

`default_nettype wire

// ===== hdl/dtaq_ram.sv =====
// ----------------------------------------------------------------------------
// dtaq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== test/dtaq_checker.sv =====
// ----------------------------------------------------------------------------
// dtaq_checker
// Watches the request, response and register ports of the depth-first tree
// block, predicts every response from its own copy of the graph and tree,
// and compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dtaq_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [dtaq_pkg::KIND_W-1:0]     req_kind,
   input  logic [dtaq_pkg::NODE_W-1:0]     req_node_a,
   input  logic [dtaq_pkg::NODE_W-1:0]     req_node_b,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [dtaq_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [dtaq_pkg::NODE_W-1:0]     rsp_parent_node,
   input  logic                            rsp_has_parent,
   input  logic [dtaq_pkg::LEV_W-1:0]      rsp_depth_level,
   input  logic                            rsp_is_descendant,
   input  logic [dtaq_pkg::NODE_W-1:0]     rsp_common_ancestor,
   input  logic                            csr_wr_en,
   input  logic [dtaq_pkg::CSR_IW-1:0]     csr_index,
   input  logic [dtaq_pkg::CNT_W-1:0]      csr_data,
   output int                              error_count,
   output int                              pending,
   output int                              checked
);
   import dtaq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   parent_node;
      logic                has_parent;
      logic [LEV_W-1:0]    depth_level;
      logic                is_descendant;
      logic [NODE_W-1:0]   common_ancestor;
   } tree_answer_type;

   tree_answer_type answers_due[$];

   int                node_total;
   int                root_sel;
   int                list_len [MAX_NODES];
   logic [NODE_W-1:0] adj      [MAX_NODES][MAX_DEGREE];
   logic [NODE_W-1:0] up_node  [MAX_NODES];
   int                depth_of [MAX_NODES];
   bit                reached  [MAX_NODES];
   int                walk     [STACK_DEPTH];
   int                walk_top;
   bit                tree_valid;

   initial begin
      error_count = 0;
      pending     = 0;
      checked     = 0;
   end

   function automatic void clear_graph_model();
      node_total = MAX_NODES;
      root_sel   = 0;
      walk_top   = 0;
      tree_valid = 0;
      for (int i = 0; i < MAX_NODES; i++) begin
         list_len[i] = 0;
         depth_of[i] = 0;
         reached[i]  = 0;
         up_node[i]  = '0;
      end
   endfunction

   function automatic int nodes_live();
      if (node_total == 0) return 1;
      if (node_total > MAX_NODES) return MAX_NODES;
      return node_total;
   endfunction

   function automatic bit push_child(int w, int v);
      if (reached[w]) return 1;
      if (walk_top >= STACK_DEPTH) return 0;
      walk[walk_top] = w;
      walk_top++;
      up_node[w]  = v[NODE_W-1:0];
      depth_of[w] = depth_of[v] + 1;
      return 1;
   endfunction

   function automatic logic [STATUS_W-1:0] grow_tree();
      int n;
      int v;
      bit ok;
      n = nodes_live();
      tree_valid = 0;
      if (root_sel >= n) return ST_RANGE;
      for (int i = 0; i < MAX_NODES; i++) begin
         reached[i]  = 0;
         depth_of[i] = 0;
      end
      walk_top = 0;
      depth_of[root_sel] = 1;
      walk[walk_top] = root_sel;
      walk_top++;
      while (walk_top > 0) begin
         walk_top--;
         v  = walk[walk_top];
         ok = 1;
         if (v >= n || reached[v]) continue;
         reached[v] = 1;
         if (v == 0) begin
            for (int w = n - 1; w >= 1 && ok; w--) ok = push_child(w, v);
         end else begin
            // hub link sits in slot zero, so it is pushed last
            for (int k = list_len[v]; k >= 1 && ok; k--)
               if (adj[v][k] < n) ok = push_child(adj[v][k], v);
            if (ok) ok = push_child(0, v);
         end
         if (!ok) begin
            walk_top = 0;
            return ST_OVERFLOW;
         end
      end
      tree_valid = 1;
      return ST_OK;
   endfunction

   function automatic logic [STATUS_W-1:0] link_nodes(int u, int v);
      int n;
      n = nodes_live();
      if (u == 0 || v == 0 || u >= n || v >= n) return ST_RANGE;
      if (u == v) begin
         if (list_len[u] + 2 > MAX_DEGREE - 1) return ST_FULL;
      end else if (list_len[u] >= MAX_DEGREE - 1 || list_len[v] >= MAX_DEGREE - 1) begin
         return ST_FULL;
      end
      list_len[u]++;
      adj[u][list_len[u]] = v[NODE_W-1:0];
      list_len[v]++;
      adj[v][list_len[v]] = u[NODE_W-1:0];
      return ST_OK;
   endfunction

   function automatic int climb_to(int c, int target);
      int guard;
      guard = 0;
      while (depth_of[c] > target && depth_of[c] >= 2 && guard < MAX_NODES) begin
         c = up_node[c];
         guard++;
      end
      return c;
   endfunction

   function automatic int meet_point(int a, int b);
      int guard;
      guard = 0;
      a = climb_to(a, depth_of[b]);
      b = climb_to(b, depth_of[a]);
      while (a != b && depth_of[a] >= 2 && depth_of[b] >= 2 && guard < MAX_NODES) begin
         a = up_node[a];
         b = up_node[b];
         guard++;
      end
      return a;
   endfunction

   function automatic tree_answer_type answer_request(logic [KIND_W-1:0] kind, int a, int b);
      tree_answer_type r;
      int n;
      r = '0;
      n = nodes_live();
      case (kind)
         KIND_CLEAR: begin
            for (int i = 0; i < MAX_NODES; i++) list_len[i] = 0;
            tree_valid = 0;
         end
         KIND_EDGE:  r.status = link_nodes(a, b);
         KIND_BUILD: r.status = grow_tree();
         KIND_QUERY, KIND_DESC, KIND_LCA: begin
            if (!tree_valid) r.status = ST_NOT_BUILT;
            else if (a >= n || (kind != KIND_QUERY && b >= n)) r.status = ST_RANGE;
            else if (kind == KIND_QUERY) begin
               r.depth_level = depth_of[a][LEV_W-1:0];
               if (depth_of[a] >= 2) begin
                  r.has_parent  = 1;
                  r.parent_node = up_node[a];
               end
            end else if (kind == KIND_DESC) begin
               r.is_descendant = (a == b) || (climb_to(a, depth_of[b]) == b);
            end else begin
               r.common_ancestor = meet_point(a, b);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      tree_answer_type want;
      if (reset) begin
         clear_graph_model();
         answers_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_NODE_COUNT) node_total = csr_data;
            else root_sel = csr_data[NODE_W-1:0];
            tree_valid = 0;
         end
         if (req_valid && !req_stall)
            answers_due.push_back(answer_request(req_kind, req_node_a, req_node_b));
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (answers_due.size() == 0) begin
               $display("%0t: response with none expected, status %0d", $time, rsp_status);
               error_count++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("parent_node", want.parent_node, rsp_parent_node);
               check_field("has_parent", want.has_parent, rsp_has_parent);
               check_field("depth_level", want.depth_level, rsp_depth_level);
               check_field("is_descendant", want.is_descendant, rsp_is_descendant);
               check_field("common_ancestor", want.common_ancestor, rsp_common_ancestor);
            end
         end
      end
      pending = answers_due.size();
   end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the depth-first tree block with a directed opening and then random
// phases of edges, builds and ancestor queries over a range of node counts
// and roots, with random gaps on both channels; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
   import dtaq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int PHASES = 9;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [NODE_W-1:0]   req_node_a = '0;
   logic [NODE_W-1:0]   req_node_b = '0;
   logic                rsp_valid;
   logic                rsp_stall = 0;
   logic [STATUS_W-1:0] rsp_status;
   logic [NODE_W-1:0]   rsp_parent_node;
   logic                rsp_has_parent;
   logic [LEV_W-1:0]    rsp_depth_level;
   logic                rsp_is_descendant;
   logic [NODE_W-1:0]   rsp_common_ancestor;
   logic                csr_wr_en = 0;
   logic [CSR_IW-1:0]   csr_index = '0;
   logic [CNT_W-1:0]    csr_data = '0;

   int error_count, pending, checked;
   int cycles = 0;
   int sent = 0;
   bit steady = 0;

   int phase_count [PHASES] = '{64, 1024, 2047, 1, 0, 200, 16, 300, 8};
   int phase_root  [PHASES] = '{0, 0, 1023, 0, 0, 17, 15, 299, 3};

   dfs_tree_with_ancestor_queries dut (.*);

   dtaq_checker scoreboard (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      rsp_stall <= !steady && ($urandom_range(99) < 20);
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send(logic [KIND_W-1:0] kind, int a, int b);
      req_valid  <= 1;
      req_kind   <= kind;
      req_node_a <= a[NODE_W-1:0];
      req_node_b <= b[NODE_W-1:0];
      do @(posedge clock); while (req_stall);
      sent++;
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold off until every outstanding transaction has answered
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IW-1:0] index, int value);
      csr_wr_en <= 1;
      csr_index <= index;
      csr_data  <= value[CNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   function automatic int pick_node(int n);
      if ($urandom_range(9) == 0) return $urandom_range(MAX_NODES - 1);
      return $urandom_range(n - 1);
   endfunction

   initial begin
      int n;
      int roll;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed opening at the reset settings
      send(KIND_QUERY, 1, 0);
      send(KIND_LCA, 1, 2);
      send(KIND_BUILD, 0, 0);
      send(KIND_EDGE, 0, 5);
      send(KIND_EDGE, 1023, 1023);
      send(KIND_EDGE, 5, 5);
      send(KIND_EDGE, 1, 2);
      send(KIND_EDGE, 2, 3);
      send(KIND_BUILD, 0, 0);
      send(KIND_QUERY, 0, 0);
      send(KIND_QUERY, 3, 0);
      send(KIND_QUERY, 1023, 1023);
      send(KIND_DESC, 3, 2);
      send(KIND_DESC, 2, 3);
      send(KIND_DESC, 5, 5);
      send(KIND_LCA, 3, 1);
      send(KIND_LCA, 1023, 1);
      send(KIND_LCA, 0, 0);
      send(KIND_SPARE_A, 1023, 1023);
      send(KIND_SPARE_B, 0, 0);
      send(KIND_CLEAR, 0, 0);
      send(KIND_QUERY, 3, 0);
      drain();

      // root beyond the node count
      write_reg(CSR_NODE_COUNT, 16);
      write_reg(CSR_ROOT_NODE, 1023);
      send(KIND_BUILD, 0, 0);
      send(KIND_QUERY, 1, 0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_reg(CSR_NODE_COUNT, phase_count[p]);
         write_reg(CSR_ROOT_NODE, phase_root[p]);
         n = phase_count[p] == 0 ? 1 : (phase_count[p] > MAX_NODES ? MAX_NODES : phase_count[p]);
         steady = (p == 1);
         for (int i = 0; i < 110; i++) begin
            roll = $urandom_range(99);
            if (i == 55) drain();
            if (roll < 3)        send(KIND_CLEAR, pick_node(n), pick_node(n));
            else if (roll < 38)  send(KIND_EDGE, pick_node(n), pick_node(n));
            else if (roll < 45)  send(KIND_BUILD, pick_node(n), pick_node(n));
            else if (roll < 62)  send(KIND_QUERY, pick_node(n), pick_node(n));
            else if (roll < 79)  send(KIND_DESC, pick_node(n), pick_node(n));
            else if (roll < 97)  send(KIND_LCA, pick_node(n), pick_node(n));
            else                 send(roll[0] ? KIND_SPARE_A : KIND_SPARE_B,
                                      pick_node(n), pick_node(n));
         end
         steady = 0;
      end

      drain();
      repeat (100) @(posedge clock);
      $display("Run covered %0d requests over %0d register settings; %0d responses checked.",
               sent, PHASES + 2, checked);
      if (error_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
